### design/lodc_pkg.sv
// Package with shared constants and status codes for the lock order checker.
`default_nettype none
package lodc_pkg;
    localparam int TABLE_ENTRIES_DEF = 1024;
    localparam int STACK_DEPTH_DEF = 32;
    localparam int THREADS_DEF = 4;
    localparam int LOCK_ID_BITS_DEF = 16;
    localparam int LOCK_FIELD_BITS = 16;
    localparam int TID_FIELD_BITS = 2;
    localparam int STATUS_BITS = 3;
    localparam int PAIRS_BITS = 6;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVERSION = 3'd1,
        ST_TOO_DEEP  = 3'd2,
        ST_DANGLING  = 3'd3,
        ST_UNPAIRED  = 3'd4,
        ST_HALTED    = 3'd5
    } status_t;

    localparam logic OP_ACQUIRE = 1'b0;
endpackage
`default_nettype wire

### design/lodc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lodc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/lock_order_deadlock_checker_unit.sv
// Top level of the lock order checker: sequencer around stack and pair memories.
// A release checks the top of the thread's stack, and a halted item goes straight to the result;
// an acquire sweeps the pair table once per held lock, up to STACK_DEPTH table sweeps, and
// appends each new pair when the scan reaches the first empty slot.
// The table scan reads one slot at a time and compares it in S_PWAIT.
// One item is worked at a time; s_tready is high only while the sequencer is idle.
// Reset (rst_n, asynchronous) clears stack heights, the pair count and the halt flag.
`default_nettype none
module lock_order_deadlock_checker_unit #(
    parameter int TABLE_ENTRIES = lodc_pkg::TABLE_ENTRIES_DEF,
    parameter int STACK_DEPTH   = lodc_pkg::STACK_DEPTH_DEF,
    parameter int THREADS       = lodc_pkg::THREADS_DEF,
    parameter int LOCK_ID_BITS  = lodc_pkg::LOCK_ID_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // opcode[0], thread_id[2:1], lock_id[18:3]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // status[2:0], new_pairs[8:3]
);
    localparam int TB = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int HB = $clog2(STACK_DEPTH + 1);
    localparam int PB = $clog2(TABLE_ENTRIES);
    localparam int UB = $clog2(TABLE_ENTRIES + 1);
    localparam int LB = (LOCK_ID_BITS < lodc_pkg::LOCK_FIELD_BITS) ? LOCK_ID_BITS
                                                                   : lodc_pkg::LOCK_FIELD_BITS;
    localparam int SD = THREADS * STACK_DEPTH;
    localparam int SAB = (SD > 1) ? $clog2(SD) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_HREAD, S_HWAIT, S_SCAN, S_PWAIT, S_OUT
    } state_t;

    state_t               state_reg;
    logic [HB-1:0]        height_reg [THREADS];
    logic [UB-1:0]        used_reg;
    logic                 halted_reg;
    logic                 op_reg;
    logic [TB-1:0]        tid_reg;
    logic [LB-1:0]        lk_reg;
    logic [HB-1:0]        h_reg;
    logic [HB-1:0]        idx_reg;
    logic [UB-1:0]        j_reg;
    logic                 inv_reg;
    logic [LB-1:0]        held_reg;
    logic [5:0]           added_reg;
    logic [2:0]           status_reg;
    logic                 rd_pending_reg;

    logic                 s_we, p_we;
    logic [SAB-1:0]       s_waddr, s_raddr;
    logic [LB-1:0]        s_wdata, s_rdata;
    logic [PB-1:0]        p_waddr, p_raddr;
    logic [2*LB-1:0]      p_rdata;

    logic                 in_op;
    logic [TB-1:0]        in_tid;
    logic [LB-1:0]        in_lk;
    logic [lodc_pkg::TID_FIELD_BITS-1:0] raw_tid;

    // The thread field is folded into range by repeated compare and subtract.
    function automatic logic [TB-1:0] wrap_tid(logic [lodc_pkg::TID_FIELD_BITS-1:0] raw);
        int v;
        v = int'(raw);
        for (int k = 0; k < (1 << lodc_pkg::TID_FIELD_BITS); k++)
        begin
            if (v >= THREADS)
            begin
                v = v - THREADS;
            end
        end
        return TB'(v);
    endfunction

    assign in_op   = s_tdata[0];
    assign raw_tid = s_tdata[2:1];
    assign in_tid  = wrap_tid(raw_tid);
    assign in_lk   = s_tdata[3 +: LB];

    function automatic logic [SAB-1:0] saddr(logic [TB-1:0] t, logic [HB-1:0] i);
        logic [SAB+HB:0] a;
        a = (SAB+HB+1)'(t) * (SAB+HB+1)'(STACK_DEPTH) + (SAB+HB+1)'(i);
        return a[SAB-1:0];
    endfunction

    lodc_ram #(.WIDTH(LB), .DEPTH(SD)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(s_raddr), .rdata(s_rdata)
    );

    lodc_ram #(.WIDTH(2*LB), .DEPTH(TABLE_ENTRIES)) u_pairs (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata({lk_reg, held_reg}),
        .raddr(p_raddr), .rdata(p_rdata)
    );

    logic [LB-1:0] pf, ps;
    assign pf = p_rdata[LB-1:0];
    assign ps = p_rdata[2*LB-1:LB];

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {7'd0, added_reg, status_reg};

    // Stack write happens on the push of an accepted acquire (in S_HREAD when done).
    logic push_now;
    assign push_now = (state_reg == S_HREAD) && !op_reg && (idx_reg == h_reg)
                      && (h_reg < HB'(STACK_DEPTH));
    assign s_we    = push_now;
    assign s_waddr = saddr(tid_reg, h_reg);
    assign s_wdata = lk_reg;
    assign s_raddr = (state_reg == S_IDLE) ? saddr(in_tid, HB'(0))
                   : (op_reg ? saddr(tid_reg, h_reg - HB'(1)) : saddr(tid_reg, idx_reg));
    assign p_raddr = j_reg[PB-1:0];
    // The pair is appended when the scan reaches the first empty slot.
    assign p_we    = (state_reg == S_SCAN) && !rd_pending_reg && (j_reg == used_reg)
                     && (used_reg < UB'(TABLE_ENTRIES));
    assign p_waddr = used_reg[PB-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            used_reg   <= '0;
            halted_reg <= 1'b0;
            rd_pending_reg <= 1'b0;
            for (int t = 0; t < THREADS; t++)
            begin
                height_reg[t] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= in_op;
                        tid_reg   <= in_tid;
                        lk_reg    <= in_lk;
                        h_reg     <= height_reg[in_tid];
                        idx_reg   <= '0;
                        added_reg <= '0;
                        if (halted_reg)
                        begin
                            status_reg <= lodc_pkg::ST_HALTED;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_HREAD;
                        end
                    end
                end
                S_HREAD:
                begin
                    // Address for idx_reg (or the top on release) is presented now.
                    if (op_reg)
                    begin
                        if (h_reg == '0)
                        begin
                            status_reg <= lodc_pkg::ST_DANGLING;
                            halted_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_HWAIT;
                        end
                    end
                    else if (idx_reg == h_reg)
                    begin
                        if (h_reg >= HB'(STACK_DEPTH))
                        begin
                            status_reg <= lodc_pkg::ST_TOO_DEEP;
                            halted_reg <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= lodc_pkg::ST_OK;
                            height_reg[tid_reg] <= h_reg + HB'(1);
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        state_reg <= S_HWAIT;
                    end
                end
                S_HWAIT:
                begin
                    if (op_reg)
                    begin
                        height_reg[tid_reg] <= h_reg - HB'(1);
                        if (s_rdata != lk_reg)
                        begin
                            status_reg <= lodc_pkg::ST_UNPAIRED;
                            halted_reg <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= lodc_pkg::ST_OK;
                        end
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        held_reg       <= s_rdata;
                        j_reg          <= '0;
                        inv_reg        <= 1'b0;
                        rd_pending_reg <= 1'b1;
                        state_reg      <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // rd_pending_reg set: slot j_reg is being read this cycle.
                    if (rd_pending_reg)
                    begin
                        if (j_reg == used_reg || j_reg >= UB'(TABLE_ENTRIES))
                        begin
                            rd_pending_reg <= 1'b0;
                        end
                        else
                        begin
                            state_reg <= S_PWAIT;
                        end
                    end
                    else
                    begin
                        if (p_we)
                        begin
                            used_reg  <= used_reg + UB'(1);
                            if (added_reg != 6'd63)
                            begin
                                added_reg <= added_reg + 6'd1;
                            end
                        end
                        if (inv_reg)
                        begin
                            status_reg <= lodc_pkg::ST_INVERSION;
                            halted_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + HB'(1);
                            state_reg <= S_HREAD;
                        end
                    end
                end
                S_PWAIT:
                begin
                    if (pf == held_reg && ps == lk_reg)
                    begin
                        if (inv_reg)
                        begin
                            status_reg <= lodc_pkg::ST_INVERSION;
                            halted_reg <= 1'b1;
                            state_reg  <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + HB'(1);
                            state_reg <= S_HREAD;
                        end
                    end
                    else
                    begin
                        if (pf == lk_reg && ps == held_reg)
                        begin
                            inv_reg <= 1'b1;
                        end
                        j_reg          <= j_reg + UB'(1);
                        rd_pending_reg <= 1'b1;
                        state_reg      <= S_SCAN;
                    end
                end
                S_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

### tb/tb_lock_order_deadlock_checker_unit.sv
// Self-checking testbench for the lock order checker: directed table, random lock sequences, one fault.
`default_nettype none
module tb_lock_order_deadlock_checker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_THREADS = 4;
    localparam int STACK_LIMIT = 32;
    localparam int N_SLOTS = 1024;
    localparam int POOL_SIZE = 48;
    localparam int RANDOM_ITEMS = 540;
    localparam logic OP_RELEASE = 1'b1;

    typedef struct packed {
        logic        op;
        logic [1:0]  tid;
        logic [15:0] lock_id;
        logic        typed;
        lodc_pkg::status_t status;
        logic [5:0]  pairs;
    } stim_row_t;

    typedef struct packed {
        lodc_pkg::status_t status;
        logic [5:0] pairs;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    lock_order_deadlock_checker_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Predictor state for the checker.
    logic [15:0] held_locks [N_THREADS][STACK_LIMIT];
    int          held_count [N_THREADS];
    logic [15:0] order_first [N_SLOTS];
    logic [15:0] order_second [N_SLOTS];
    int          orders_filled;
    bit          checker_halted;

    verdict_t    expected_verdicts [$];
    // Rows with typed-in results, checked on top of the predictor.
    verdict_t    typed_verdicts [$];
    bit          typed_flags [$];

    int          mismatches = 0;
    int          results_seen = 0;
    int          status_seen [8];
    int          acquires_sent = 0;
    int          releases_sent = 0;
    bit          sender_idle_free = 0;
    bit          receiver_idle_free = 0;

    // Shadow of each thread's stack as pool indexes, used to build legal sequences.
    int          shadow_stack [N_THREADS][$];
    logic [15:0] lock_pool [POOL_SIZE];

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit order_check(logic [15:0] a, logic [15:0] b, ref int added);
        bit inverted;
        inverted = 0;
        for (int j = 0; j < orders_filled; j++)
        begin
            if (order_first[j] == a && order_second[j] == b)
                return inverted;
            if (order_first[j] == b && order_second[j] == a)
                inverted = 1;
        end
        if (orders_filled < N_SLOTS)
        begin
            order_first[orders_filled] = a;
            order_second[orders_filled] = b;
            orders_filled++;
            added++;
        end
        return inverted;
    endfunction

    function automatic verdict_t judge_event(logic op, logic [1:0] tid, logic [15:0] lk);
        verdict_t v;
        int added;
        int h;
        added = 0;
        v.pairs = '0;
        if (checker_halted)
        begin
            v.status = lodc_pkg::ST_HALTED;
            return v;
        end
        h = held_count[tid];
        if (op == lodc_pkg::OP_ACQUIRE)
        begin
            for (int i = 0; i < h; i++)
            begin
                if (order_check(held_locks[tid][i], lk, added))
                begin
                    checker_halted = 1;
                    v.status = lodc_pkg::ST_INVERSION;
                    v.pairs = (added > 63) ? 6'd63 : added[5:0];
                    return v;
                end
            end
            v.pairs = (added > 63) ? 6'd63 : added[5:0];
            if (h >= STACK_LIMIT)
            begin
                checker_halted = 1;
                v.status = lodc_pkg::ST_TOO_DEEP;
                return v;
            end
            held_locks[tid][h] = lk;
            held_count[tid] = h + 1;
            v.status = lodc_pkg::ST_OK;
            return v;
        end
        if (h == 0)
        begin
            checker_halted = 1;
            v.status = lodc_pkg::ST_DANGLING;
            return v;
        end
        held_count[tid] = h - 1;
        if (held_locks[tid][h - 1] != lk)
        begin
            checker_halted = 1;
            v.status = lodc_pkg::ST_UNPAIRED;
            return v;
        end
        v.status = lodc_pkg::ST_OK;
        return v;
    endfunction

    // Input side: predict every accepted item.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_verdicts.push_back(judge_event(s_tdata[0], s_tdata[2:1], s_tdata[18:3]));
    end

    // Output side: compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        verdict_t want;
        verdict_t typed;
        bit has_typed;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            status_seen[m_tdata[2:0]]++;
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no item pending: status %0d new_pairs %0d",
                       m_tdata[2:0], m_tdata[8:3]);
                mismatches++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                has_typed = 0;
                if (typed_flags.size() > 0)
                begin
                    has_typed = typed_flags.pop_front();
                    typed = typed_verdicts.pop_front();
                end
                if (has_typed && typed != want)
                begin
                    $error("predictor disagrees with table: status %0d/%0d pairs %0d/%0d",
                           typed.status, want.status, typed.pairs, want.pairs);
                    mismatches++;
                end
                if (m_tdata[2:0] != want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[2:0]);
                    mismatches++;
                end
                if (m_tdata[8:3] != want.pairs)
                begin
                    $error("new_pairs: expected %0d, actual %0d", want.pairs, m_tdata[8:3]);
                    mismatches++;
                end
            end
        end
    end

    task automatic offer_event(logic op, logic [1:0] tid, logic [15:0] lk);
        int gap;
        gap = sender_idle_free ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'b0, lk, tid, op};
        if (op == lodc_pkg::OP_ACQUIRE)
            acquires_sent++;
        else
            releases_sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic acquire_idx(int t, int idx);
        shadow_stack[t].push_back(idx);
        offer_event(lodc_pkg::OP_ACQUIRE, t[1:0], lock_pool[idx]);
    endtask

    task automatic release_top(int t);
        int idx;
        idx = shadow_stack[t].pop_back();
        offer_event(OP_RELEASE, t[1:0], lock_pool[idx]);
    endtask

    task automatic release_all(int t);
        while (shadow_stack[t].size() > 0)
            release_top(t);
    endtask

    // Receiver: random stalls per result, plus one long hold-off to back up the input.
    initial
    begin
        bit long_hold_done;
        int gap;
        long_hold_done = 0;
        m_tready <= 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (!long_hold_done && results_seen >= 150)
            begin
                long_hold_done = 1;
                m_tready <= 1'b0;
                repeat (600) @(posedge clk);
            end
            gap = receiver_idle_free ? 0 : $urandom_range(0, 8);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        #2_000_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t r;
        logic [15:0] tmp;
        int t;
        int lo;
        int fault_kind;

        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        for (int i = 0; i < N_THREADS; i++)
            held_count[i] = 0;
        orders_filled = 0;
        checker_halted = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Sorted pool of lock ids; acquiring in pool order never inverts.
        lock_pool[0] = 16'd1;
        lock_pool[POOL_SIZE - 1] = 16'hFFFF;
        for (int i = 1; i < POOL_SIZE - 1; i++)
            lock_pool[i] = 16'($urandom_range(2, 65534));
        for (int i = 0; i < POOL_SIZE; i++)
            for (int j = i + 1; j < POOL_SIZE; j++)
                if (lock_pool[j] < lock_pool[i])
                begin
                    tmp = lock_pool[i];
                    lock_pool[i] = lock_pool[j];
                    lock_pool[j] = tmp;
                end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: all legal; thread 0 is left holding ids 1 and 65535.
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd0, 16'd1,    1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd0, 16'hFFFF, 1'b1, lodc_pkg::ST_OK, 6'd1});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd3, 16'hAAAA, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd3, 16'hAAAA, 1'b0, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd3, 16'hFFFF, 1'b0, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd3, 16'hFFFF, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd3, 16'hAAAA, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd3, 16'hAAAA, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd1, 16'h5555, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd1, 16'hFFFF, 1'b0, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd1, 16'hFFFF, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd1, 16'h5555, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd2, 16'd1,    1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{lodc_pkg::OP_ACQUIRE, 2'd2, 16'hFFFF, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd2, 16'hFFFF, 1'b1, lodc_pkg::ST_OK, 6'd0});
        rows.push_back('{OP_RELEASE, 2'd2, 16'd1,    1'b1, lodc_pkg::ST_OK, 6'd0});
        foreach (rows[i])
        begin
            r = rows[i];
            typed_flags.push_back(r.typed);
            typed_verdicts.push_back('{r.status, r.pairs});
            offer_event(r.op, r.tid, r.lock_id);
        end
        shadow_stack[0].push_back(0);
        shadow_stack[0].push_back(POOL_SIZE - 1);

        // Random legal sequences: ascending acquires, last-in-first-out releases.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 90 == 0)
            begin
                sender_idle_free = ($urandom_range(0, 3) == 0);
                receiver_idle_free = ($urandom_range(0, 3) == 0);
            end
            t = $urandom_range(0, N_THREADS - 1);
            if (shadow_stack[t].size() == 0 ||
                (shadow_stack[t].size() < 6 && $urandom_range(0, 1) == 1))
            begin
                lo = (shadow_stack[t].size() == 0) ? 0 : shadow_stack[t][$];
                acquire_idx(t, $urandom_range(lo, POOL_SIZE - 1));
            end
            else
                release_top(t);
        end
        sender_idle_free = 0;
        receiver_idle_free = 0;

        // One fault per run, then a few items against the halted block.
        fault_kind = $urandom_range(0, 3);
        release_all(1);
        case (fault_kind)
            0:
            begin
                acquire_idx(1, POOL_SIZE - 1);
                acquire_idx(1, 0);
            end
            1:
            begin
                for (int i = 0; i <= STACK_LIMIT; i++)
                    acquire_idx(1, 0);
            end
            2:
                offer_event(OP_RELEASE, 2'd1, 16'd1);
            default:
            begin
                acquire_idx(1, 0);
                offer_event(OP_RELEASE, 2'd1, 16'hFFFF);
            end
        endcase
        for (int i = 0; i < 4; i++)
            offer_event(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                        16'($urandom_range(1, 65535)));
        s_tvalid <= 1'b0;

        while (expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Sent %0d acquires and %0d releases; %0d results, ordering table held %0d pairs.",
                 acquires_sent, releases_sent, results_seen, orders_filled);
        $display("Status counts ok/inv/deep/dangling/unpaired/halted: %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

### files.f
design/lodc_pkg.sv
design/lodc_ram.sv
design/lock_order_deadlock_checker_unit.sv
tb/tb_lock_order_deadlock_checker_unit.sv
